[rtl/tcae_pkg.sv]
// Package with shared types, constants and SKINNY round helpers for the AEAD engine.
package tcae_pkg;

    localparam int CipherRounds = 56;
    localparam int TagBytes     = 16;
    localparam int CtrHalf      = 60;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_AD     = 2'd1,
        OP_MSG    = 2'd2,
        OP_FINISH = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_ACK  = 2'd0,
        KIND_TEXT = 2'd1,
        KIND_TAG  = 2'd2
    } t_kind;

    localparam logic [1:0] CfgKeyHi = 2'd0;
    localparam logic [1:0] CfgKeyLo = 2'd1;
    localparam logic [1:0] CfgMode  = 2'd2;

    localparam logic [7:0] DomStart  = 8'h00;
    localparam logic [7:0] DomAdFull = 8'h01;
    localparam logic [7:0] DomAdPad  = 8'h02;
    localparam logic [7:0] DomMsgFul = 8'h03;
    localparam logic [7:0] DomMsgPad = 8'h04;
    localparam logic [7:0] DomTag    = 8'hFF;
    localparam logic [7:0] PadByte   = 8'h80;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] data_hi;
        logic [63:0] data_lo;
        logic [4:0]  valid_bytes;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] out_hi;
        logic [63:0] out_lo;
        logic [4:0]  out_bytes;
        logic        tag_ok;
    } t_out;

    // Request from the sequencer to the round unit.
    typedef struct packed {
        logic         start;
        logic [127:0] state;
        logic [127:0] tk1;
        logic [127:0] tk2;
        logic [127:0] tk3;
    } t_rnd_req;

    // Byte i of a 128-bit block, byte 0 at the top.
    function automatic logic [7:0] get_byte(input logic [127:0] w, input int i);
        return w[127-8*i -: 8];
    endfunction

    function automatic logic [7:0] sb_mix(input logic [7:0] x);
        logic [7:0] t;
        t = ((x >> 1) | x) >> 2;
        return (~t & 8'h11) ^ x;
    endfunction

    function automatic logic [7:0] sb_perm(input logic [7:0] x);
        return ((x & 8'h01) << 2) | ((x & 8'h06) << 5) | ((x & 8'h20) >> 5) |
               ((x & 8'hC8) >> 2) | ((x & 8'h10) >> 1);
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] x;
        x = sb_perm(sb_mix(a));
        x = sb_perm(sb_mix(x));
        x = sb_perm(sb_mix(x));
        x = sb_mix(x);
        return (x & 8'hF9) | ((x >> 1) & 8'h02) | ((x << 1) & 8'h04);
    endfunction

    // Tweakey byte permutation.
    function automatic logic [127:0] tk_permute(input logic [127:0] t);
        logic [127:0] r;
        logic [3:0]   p [16];
        p = '{4'd9, 4'd15, 4'd8, 4'd13, 4'd10, 4'd14, 4'd12, 4'd11,
              4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7};
        for (int i = 0; i < 16; i++) begin
            r[127-8*i -: 8] = get_byte(t, int'(p[i]));
        end
        return r;
    endfunction

endpackage

[rtl/tweakable_cipher_aead_engine.sv]
// Top level of the SKINNY-128-384 AEAD engine: sequencer, chain state and result register.
//  channel | direction | handshake
//  input   | in        | i_in_valid / o_in_ready, payload i_in
//  output  | out       | o_out_valid / i_out_ready, payload o_out
//  config  | in        | i_cfg_we, i_cfg_idx, i_cfg_data
// Each item passes through these steps from one input transaction to the next: the
// round unit is launched, then loaded, runs its 56 rounds, the result is registered
// and the output transaction follows. The result register frees before the next item is
// taken, so a stalled output holds off input for as long as it stalls.
// Reset clears key, mode, chain value, counter and previous block.
module tweakable_cipher_aead_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tcae_pkg::t_in    i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output tcae_pkg::t_out   o_out,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [63:0]      i_cfg_data
);
    import tcae_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state       r_fsm;
    logic [63:0]  r_key_hi, r_key_lo;
    logic         r_dec;
    logic [127:0] r_chain, r_prev;
    logic [119:0] r_ctr;
    t_in          r_item;
    logic [127:0] r_txt;
    logic [4:0]   r_n;
    t_out         r_out;
    logic         r_start;
    logic [127:0] r_h;
    logic [7:0]   r_dom;
    t_rnd_req     w_req;
    logic         w_done;
    logic [127:0] w_res;

    // Block preparation: padding, text and next chain input.
    logic [127:0] w_h, w_tw, w_txt, w_d;
    logic [4:0]   w_n;
    logic [7:0]   w_dom;
    always_comb begin
        logic [7:0] hb, db;
        w_n   = (i_in.valid_bytes > 5'd16) ? 5'd16 : i_in.valid_bytes;
        w_d   = {i_in.data_hi, i_in.data_lo};
        w_h   = r_chain;
        w_tw  = '0;
        w_txt = '0;
        w_dom = DomStart;
        case (t_op'(i_in.op))
            OP_START: begin
                w_h = w_d;
            end
            OP_AD, OP_MSG: begin
                for (int i = 0; i < 16; i++) begin
                    hb = get_byte(r_chain, i);
                    db = get_byte(w_d, i);
                    if (i < int'(w_n)) begin
                        if (i_in.op == OP_MSG && r_dec) begin
                            w_txt[127-8*i -: 8] = hb ^ db;
                            w_tw[127-8*i -: 8]  = hb ^ db;
                            w_h[127-8*i -: 8]   = db;
                        end else begin
                            w_tw[127-8*i -: 8]  = db;
                            w_h[127-8*i -: 8]   = hb ^ db;
                            w_txt[127-8*i -: 8] = hb ^ db;
                        end
                    end else if (i == int'(w_n)) begin
                        w_tw[127-8*i -: 8] = PadByte;
                        w_h[127-8*i -: 8]  = hb ^ PadByte;
                    end
                end
                if (i_in.op == OP_AD) w_dom = (w_n == 5'd16) ? DomAdFull : DomAdPad;
                else                  w_dom = (w_n == 5'd16) ? DomMsgFul : DomMsgPad;
            end
            default: begin
                w_dom = DomTag;
            end
        endcase
    end

    assign o_in_ready  = (r_fsm == S_IDLE);
    assign o_out_valid = (r_fsm == S_OUT);
    assign o_out       = r_out;

    assign w_req.start = r_start;
    assign w_req.state = r_h;
    assign w_req.tk1   = {r_ctr, r_dom};
    assign w_req.tk2   = r_prev;
    assign w_req.tk3   = {r_key_hi, r_key_lo};

    tcae_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_done),
        .o_state (w_res)
    );

    // Sequencer and chain state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm    <= S_IDLE;
            r_key_hi <= '0;
            r_key_lo <= '0;
            r_dec    <= 1'b0;
            r_chain  <= '0;
            r_prev   <= '0;
            r_ctr    <= '0;
            r_start  <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgKeyHi: r_key_hi <= i_cfg_data;
                    CfgKeyLo: r_key_lo <= i_cfg_data;
                    CfgMode:  r_dec    <= i_cfg_data[0];
                    default:  ;
                endcase
            end
            case (r_fsm)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_fsm   <= S_RUN;
                        r_start <= 1'b1;
                        r_item  <= i_in;
                        r_h     <= w_h;
                        r_dom   <= w_dom;
                        r_txt   <= w_txt;
                        r_n     <= w_n;
                        if (i_in.op == OP_START) begin
                            r_ctr  <= '0;
                            r_prev <= '0;
                        end else begin
                            r_ctr  <= r_ctr + 120'd1;
                            r_prev <= (i_in.op == OP_FINISH) ? '0 : w_tw;
                        end
                    end
                end
                S_RUN: begin
                    if (w_done) begin
                        r_fsm   <= S_OUT;
                        r_chain <= w_res;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) r_fsm <= S_IDLE;
                end
                default: r_fsm <= S_IDLE;
            endcase
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (r_fsm == S_RUN && w_done) begin
            r_out <= '0;
            case (t_op'(r_item.op))
                OP_MSG: begin
                    r_out.kind      <= KIND_TEXT;
                    r_out.out_hi    <= r_txt[127:64];
                    r_out.out_lo    <= r_txt[63:0];
                    r_out.out_bytes <= r_n;
                end
                OP_FINISH: begin
                    r_out.kind <= KIND_TAG;
                    if (r_dec) begin
                        r_out.tag_ok <= (w_res == {r_item.data_hi, r_item.data_lo});
                    end else begin
                        r_out.out_hi    <= w_res[127:64];
                        r_out.out_lo    <= w_res[63:0];
                        r_out.out_bytes <= 5'(TagBytes);
                    end
                end
                default: r_out.kind <= KIND_ACK;
            endcase
        end
    end
endmodule

[rtl/tcae_round.sv]
// One SKINNY-128-384 round per cycle over a held state and tweakey.
module tcae_round (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcae_pkg::t_rnd_req i_req,
    output logic               o_done,
    output logic [127:0]       o_state
);
    import tcae_pkg::*;

    logic [127:0] r_st, n_st, r_t1, r_t2, r_t3, n_t1, n_t2, n_t3;
    logic [5:0]   r_rc, n_rc;
    logic [5:0]   r_cnt;
    logic         r_busy, r_done;

    // Combinational round function.
    always_comb begin
        logic [7:0]   s [16];
        logic [7:0]   m [16];
        logic [7:0]   a, b, c2, d3;
        logic [3:0]   rs [16];
        logic [127:0] p1, p2, p3;
        rs = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd7, 4'd4, 4'd5, 4'd6,
               4'd10, 4'd11, 4'd8, 4'd9, 4'd13, 4'd14, 4'd15, 4'd12};
        n_rc = {r_rc[4:0], r_rc[5] ^ r_rc[4] ^ 1'b1};
        for (int i = 0; i < 16; i++) begin
            s[i] = sbox(get_byte(r_st, i));
        end
        s[0] = s[0] ^ {4'd0, n_rc[3:0]};
        s[4] = s[4] ^ {6'd0, n_rc[5:4]};
        s[8] = s[8] ^ 8'h02;
        for (int i = 0; i < 8; i++) begin
            s[i] = s[i] ^ get_byte(r_t1, i) ^ get_byte(r_t2, i) ^ get_byte(r_t3, i);
        end
        p1 = tk_permute(r_t1);
        p2 = tk_permute(r_t2);
        p3 = tk_permute(r_t3);
        n_t1 = p1;
        n_t2 = p2;
        n_t3 = p3;
        for (int i = 0; i < 8; i++) begin
            a = p2[127-8*i -: 8];
            b = p3[127-8*i -: 8];
            n_t2[127-8*i -: 8] = {a[6:0], a[7] ^ a[5]};
            n_t3[127-8*i -: 8] = {b[0] ^ b[6], b[7:1]};
        end
        for (int i = 0; i < 16; i++) begin
            m[i] = s[rs[i]];
        end
        for (int c = 0; c < 4; c++) begin
            a  = m[c];
            b  = m[4+c];
            c2 = m[8+c];
            d3 = m[12+c];
            n_st[127-8*c -: 8]      = a ^ c2 ^ d3;
            n_st[127-8*(4+c) -: 8]  = a;
            n_st[127-8*(8+c) -: 8]  = b ^ c2;
            n_st[127-8*(12+c) -: 8] = a ^ c2;
        end
    end

    // Round counter and control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(CipherRounds - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_st <= i_req.state;
            r_t1 <= i_req.tk1;
            r_t2 <= i_req.tk2;
            r_t3 <= i_req.tk3;
            r_rc <= '0;
        end else if (r_busy) begin
            r_st <= n_st;
            r_t1 <= n_t1;
            r_t2 <= n_t2;
            r_t3 <= n_t3;
            r_rc <= n_rc;
        end
    end

    assign o_done  = r_done;
    assign o_state = r_st;
endmodule

[rtl/tcae_checker.sv]
// Port-level checker for the AEAD engine, bound to the top level.
module tcae_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input tcae_pkg::t_out o_out
);
    import tcae_pkg::*;

    // One item at a time: never ready while a result waits.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready while result pending");

    // An accepted transaction is not followed at once by a result.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_out_valid) else $error("result too early");

    // Stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("result changed under stall");

    // Kind is one of the three codes.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.kind == KIND_ACK || o_out.kind == KIND_TEXT ||
                         o_out.kind == KIND_TAG)) else $error("bad kind");
endmodule

bind tweakable_cipher_aead_engine tcae_checker u_tcae_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
